// File: rtl/core/vrsa_pkg.sv
package vrsa_pkg;

	// Default sizing of the buffer and the header stack.
	localparam int BUFFER_BYTES_DEF = 4096;
	localparam int HEADER_BYTES_DEF = 2;
	localparam int MAX_OBJECTS_DEF  = 2048;

	// Port field widths.
	localparam int CMD_W   = 2;
	localparam int BYTES_W = 13;
	localparam int COUNT_W = 12;

	// Capacity register value after reset.
	localparam logic [BYTES_W-1:0] CAP_RESET = 13'd4096;

	// Operation codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_POP   = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// Header stack update requested by the control logic.
	typedef struct packed {
		logic push;
		logic pop;
	} hdr_op_t;

	// Width for fill arithmetic: holds the buffer size plus a full request and pad.
	function automatic int fill_w(input int buf_bytes);
		int w;
		w = $clog2(buf_bytes + 1);
		if (w < BYTES_W) begin
			w = BYTES_W;
		end
		return w + 2;
	endfunction

	// Width of a stored header offset, always below the buffer size.
	function automatic int hdr_w(input int buf_bytes);
		return $clog2(buf_bytes);
	endfunction

	// Width of the record counter, which can reach the slot count itself.
	function automatic int cnt_w(input int max_objects);
		int w;
		w = $clog2(max_objects + 1);
		if (w < 1) begin
			w = 1;
		end
		return w;
	endfunction

	// Address width of the header memory.
	function automatic int addr_w(input int max_objects);
		int w;
		w = $clog2(max_objects);
		if (w < 1) begin
			w = 1;
		end
		return w;
	endfunction

endpackage

// File: rtl/core/variable_record_stack_allocator.sv
// Flow: an accepted command beat waits in the command register, and its result is offered
// from the result register; stage one holds while the result register is full and stalled.
// Throughput: one command per cycle unless stalled; each is a compare and add on the fill
// level plus one access to the header stack, whose two newest offsets sit in registers.
// Reset (arst_n low, asynchronous): the stack is empty, the capacity register is 4096,
// and both pipeline stages are empty. The header memory needs no clearing pass.
module variable_record_stack_allocator #(
	parameter int BUFFER_BYTES = vrsa_pkg::BUFFER_BYTES_DEF,
	parameter int HEADER_BYTES = vrsa_pkg::HEADER_BYTES_DEF,
	parameter int MAX_OBJECTS  = vrsa_pkg::MAX_OBJECTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [vrsa_pkg::BYTES_W-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [vrsa_pkg::CMD_W-1:0]    cmd,
	input  logic [vrsa_pkg::BYTES_W-1:0]  obj_size,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          ok,
	output logic [vrsa_pkg::BYTES_W-1:0]  data_offset,
	output logic [vrsa_pkg::BYTES_W-1:0]  used_bytes,
	output logic [vrsa_pkg::BYTES_W-1:0]  free_bytes,
	output logic [vrsa_pkg::COUNT_W-1:0]  object_count,
	output logic                          is_empty,
	output logic                          is_full
);

	localparam int HW = vrsa_pkg::hdr_w(BUFFER_BYTES);
	localparam int CW = vrsa_pkg::cnt_w(MAX_OBJECTS);

	logic                          valid_s1;
	logic [vrsa_pkg::CMD_W-1:0]    cmd_s1;
	logic [vrsa_pkg::BYTES_W-1:0]  size_s1;
	logic                          valid_s2;
	logic                          ok_s2;
	logic [vrsa_pkg::BYTES_W-1:0]  offset_s2;
	logic [vrsa_pkg::BYTES_W-1:0]  used_s2;
	logic [vrsa_pkg::BYTES_W-1:0]  free_s2;
	logic [vrsa_pkg::COUNT_W-1:0]  count_s2;
	logic                          empty_s2;
	logic                          full_s2;
	logic                          adv;
	logic                          in_take;
	vrsa_pkg::hdr_op_t             op;
	logic [CW-1:0]                 count;
	logic [HW-1:0]                 push_hdr;
	logic [HW-1:0]                 top;
	logic                          r_ok;
	logic [vrsa_pkg::BYTES_W-1:0]  r_offset;
	logic [vrsa_pkg::BYTES_W-1:0]  r_used;
	logic [vrsa_pkg::BYTES_W-1:0]  r_free;
	logic [vrsa_pkg::COUNT_W-1:0]  r_count;
	logic                          r_empty;
	logic                          r_full;

	// The command in stage one moves on when the result register is empty or being taken.
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	vrsa_ctrl #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.MAX_OBJECTS  (MAX_OBJECTS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.adv          (adv),
		.cmd          (cmd_s1),
		.obj_size     (size_s1),
		.top          (top),
		.op           (op),
		.count        (count),
		.push_hdr     (push_hdr),
		.ok           (r_ok),
		.data_offset  (r_offset),
		.used_bytes   (r_used),
		.free_bytes   (r_free),
		.object_count (r_count),
		.is_empty     (r_empty),
		.is_full      (r_full)
	);

	vrsa_hdr_store #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.MAX_OBJECTS  (MAX_OBJECTS)
	) u_hdr_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.count    (count),
		.push_hdr (push_hdr),
		.top      (top)
	);

	// Pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Command register and result register.
	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1  <= cmd;
			size_s1 <= obj_size;
		end
		if (adv) begin
			ok_s2     <= r_ok;
			offset_s2 <= r_offset;
			used_s2   <= r_used;
			free_s2   <= r_free;
			count_s2  <= r_count;
			empty_s2  <= r_empty;
			full_s2   <= r_full;
		end
	end

	assign out_valid    = valid_s2;
	assign ok           = ok_s2;
	assign data_offset  = offset_s2;
	assign used_bytes   = used_s2;
	assign free_bytes   = free_s2;
	assign object_count = count_s2;
	assign is_empty     = empty_s2;
	assign is_full      = full_s2;

endmodule

// File: rtl/core/vrsa_hdr_store.sv
module vrsa_hdr_store #(
	parameter int BUFFER_BYTES = vrsa_pkg::BUFFER_BYTES_DEF,
	parameter int MAX_OBJECTS  = vrsa_pkg::MAX_OBJECTS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  vrsa_pkg::hdr_op_t                       op,
	input  logic [vrsa_pkg::cnt_w(MAX_OBJECTS)-1:0] count,
	input  logic [vrsa_pkg::hdr_w(BUFFER_BYTES)-1:0] push_hdr,
	output logic [vrsa_pkg::hdr_w(BUFFER_BYTES)-1:0] top
);

	localparam int HW = vrsa_pkg::hdr_w(BUFFER_BYTES);
	localparam int CW = vrsa_pkg::cnt_w(MAX_OBJECTS);
	localparam int AW = vrsa_pkg::addr_w(MAX_OBJECTS);

	logic [HW-1:0] mem [MAX_OBJECTS];
	logic [HW-1:0] top_q;
	logic [HW-1:0] hold_q;
	logic [HW-1:0] rd_q;
	logic          use_rd_q;
	logic [HW-1:0] below;
	logic [CW-1:0] rd_cnt;

	// The second entry comes from the memory read right after a pop, else from the hold register.
	assign below  = use_rd_q ? rd_q : hold_q;
	assign top    = top_q;
	assign rd_cnt = count - CW'(3);

	// Every offset is stored in the memory; the memory is read at the entry under the second.
	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[count[AW-1:0]] <= push_hdr;
		end
		rd_q <= mem[rd_cnt[AW-1:0]];
	end

	// The two newest offsets are kept in registers so a pop finds its successor at once.
	always_ff @(posedge clk) begin
		if (op.push) begin
			top_q  <= push_hdr;
			hold_q <= top_q;
		end else if (op.pop) begin
			top_q  <= below;
			hold_q <= below;
		end else begin
			hold_q <= below;
		end
	end

	// Select flag for the second entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_rd_q <= 1'b0;
		end else begin
			use_rd_q <= op.pop;
		end
	end

endmodule

// File: rtl/core/vrsa_ctrl.sv
module vrsa_ctrl #(
	parameter int BUFFER_BYTES = vrsa_pkg::BUFFER_BYTES_DEF,
	parameter int HEADER_BYTES = vrsa_pkg::HEADER_BYTES_DEF,
	parameter int MAX_OBJECTS  = vrsa_pkg::MAX_OBJECTS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [vrsa_pkg::BYTES_W-1:0]             cfg_wdata,
	input  logic                                     adv,
	input  logic [vrsa_pkg::CMD_W-1:0]               cmd,
	input  logic [vrsa_pkg::BYTES_W-1:0]             obj_size,
	input  logic [vrsa_pkg::hdr_w(BUFFER_BYTES)-1:0] top,
	output vrsa_pkg::hdr_op_t                        op,
	output logic [vrsa_pkg::cnt_w(MAX_OBJECTS)-1:0]  count,
	output logic [vrsa_pkg::hdr_w(BUFFER_BYTES)-1:0] push_hdr,
	output logic                                     ok,
	output logic [vrsa_pkg::BYTES_W-1:0]             data_offset,
	output logic [vrsa_pkg::BYTES_W-1:0]             used_bytes,
	output logic [vrsa_pkg::BYTES_W-1:0]             free_bytes,
	output logic [vrsa_pkg::COUNT_W-1:0]             object_count,
	output logic                                     is_empty,
	output logic                                     is_full
);

	localparam int W  = vrsa_pkg::fill_w(BUFFER_BYTES);
	localparam int HW = vrsa_pkg::hdr_w(BUFFER_BYTES);
	localparam int CW = vrsa_pkg::cnt_w(MAX_OBJECTS);

	logic [vrsa_pkg::BYTES_W-1:0] cap_q;
	logic [W-1:0]                 fill_q;
	logic [CW-1:0]                count_q;
	logic [W-1:0]                 cap_eff;
	logic [W-1:0]                 free_now;
	logic [W-1:0]                 need;
	logic [W-1:0]                 sum;
	logic [W-1:0]                 padded;
	logic [W-1:0]                 fill_nx;
	logic [CW-1:0]                count_nx;
	logic [W-1:0]                 free_nx;
	logic [W-1:0]                 offset;
	logic                         alloc_ok;
	logic                         has_top;
	vrsa_pkg::cmd_t               cmd_e;

	// Capacity limited to the buffer, and the room left at the current fill.
	assign cap_eff  = (W'(cap_q) > W'(BUFFER_BYTES)) ? W'(BUFFER_BYTES) : W'(cap_q);
	assign free_now = (fill_q >= cap_eff) ? '0 : cap_eff - fill_q;
	assign need     = W'(obj_size) + W'(HEADER_BYTES);
	assign sum      = fill_q + need;
	assign padded   = sum + W'(sum[0]);
	assign alloc_ok = (free_now >= need) && (W'(count_q) < W'(MAX_OBJECTS));
	assign has_top  = (count_q != '0);
	assign cmd_e    = vrsa_pkg::cmd_t'(cmd);
	assign count    = count_q;
	assign push_hdr = fill_q[HW-1:0];

	// Decode the command into the next state and the result fields.
	always_comb begin
		fill_nx  = fill_q;
		count_nx = count_q;
		op       = '0;
		ok       = 1'b0;
		offset   = '0;
		case (cmd_e)
			vrsa_pkg::CMD_ALLOC: begin
				if (alloc_ok) begin
					fill_nx  = (padded > cap_eff) ? cap_eff : padded;
					count_nx = count_q + CW'(1);
					op.push  = adv;
					ok       = 1'b1;
					offset   = fill_q + W'(HEADER_BYTES);
				end
			end
			vrsa_pkg::CMD_POP: begin
				if (has_top) begin
					fill_nx  = W'(top);
					count_nx = count_q - CW'(1);
					op.pop   = adv;
					ok       = 1'b1;
					offset   = W'(top) + W'(HEADER_BYTES);
				end
			end
			vrsa_pkg::CMD_PEEK: begin
				if (has_top) begin
					ok     = 1'b1;
					offset = W'(top) + W'(HEADER_BYTES);
				end
			end
			vrsa_pkg::CMD_CLEAR: begin
				fill_nx  = '0;
				count_nx = '0;
				ok       = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// Status after the operation.
	assign free_nx      = (fill_nx >= cap_eff) ? '0 : cap_eff - fill_nx;
	assign data_offset  = offset[vrsa_pkg::BYTES_W-1:0];
	assign used_bytes   = fill_nx[vrsa_pkg::BYTES_W-1:0];
	assign free_bytes   = free_nx[vrsa_pkg::BYTES_W-1:0];
	assign object_count = vrsa_pkg::COUNT_W'(count_nx);
	assign is_empty     = (fill_nx == '0);
	assign is_full      = (fill_nx == cap_eff);

	// Capacity register, fill level and record count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= vrsa_pkg::CAP_RESET;
			fill_q  <= '0;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (adv) begin
				fill_q  <= fill_nx;
				count_q <= count_nx;
			end
		end
	end

endmodule

// File: tb/sv/tb.sv
module tb;
	import vrsa_pkg::*;

	localparam int SLOTS       = MAX_OBJECTS_DEF;
	localparam int NUM_DIR     = 27;
	localparam int NUM_PHASES  = 7;
	localparam int PHASE_ITEMS = 70;
	localparam int FILL_ITEMS  = 1000;
	localparam int HOLD_CYCLES = 64;
	localparam int IDLE_LIMIT  = 4000;

	localparam logic [BYTES_W-1:0] HDR_SIZE  = BYTES_W'(HEADER_BYTES_DEF);
	localparam logic [BYTES_W-1:0] BUF_LIMIT = BYTES_W'(BUFFER_BYTES_DEF);
	localparam logic [COUNT_W-1:0] SLOT_CAP  = COUNT_W'(MAX_OBJECTS_DEF);

	// One result beat, field by field.
	typedef struct packed {
		logic               ok;
		logic [BYTES_W-1:0] data_offset;
		logic [BYTES_W-1:0] used_bytes;
		logic [BYTES_W-1:0] free_bytes;
		logic [COUNT_W-1:0] object_count;
		logic               is_empty;
		logic               is_full;
	} alloc_result_t;

	// A row of the directed table: either a capacity write or a command.
	typedef struct {
		logic               is_cfg;
		cmd_t               op;
		logic [BYTES_W-1:0] value;
		logic               typed;
		alloc_result_t      lit;
	} steer_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [BYTES_W-1:0] cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [CMD_W-1:0]   cmd;
	logic [BYTES_W-1:0] obj_size;
	logic               out_valid;
	logic               out_stall;
	logic               ok;
	logic [BYTES_W-1:0] data_offset;
	logic [BYTES_W-1:0] used_bytes;
	logic [BYTES_W-1:0] free_bytes;
	logic [COUNT_W-1:0] object_count;
	logic               is_empty;
	logic               is_full;

	// Shadow of the allocator state.
	logic [BYTES_W-1:0] cap_reg  = CAP_RESET;
	logic [BYTES_W-1:0] fill_lvl = '0;
	logic [COUNT_W-1:0] rec_count = '0;
	logic [BYTES_W-1:0] hdr_offs [SLOTS];

	alloc_result_t expected_q [$];
	steer_row_t    dir_rows [NUM_DIR];
	int            fail_count  = 0;
	int            idle_cycles = 0;
	logic          hold_req    = 1'b0;
	logic          quiet       = 1'b0;

	variable_record_stack_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.obj_size     (obj_size),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ok           (ok),
		.data_offset  (data_offset),
		.used_bytes   (used_bytes),
		.free_bytes   (free_bytes),
		.object_count (object_count),
		.is_empty     (is_empty),
		.is_full      (is_full)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The capacity seen by the allocator is clipped to the buffer size.
	function automatic logic [BYTES_W-1:0] usable_capacity();
		return (cap_reg > BUF_LIMIT) ? BUF_LIMIT : cap_reg;
	endfunction

	// Free bytes never go below zero, even when the capacity drops under the fill.
	function automatic logic [BYTES_W-1:0] room_left();
		logic [BYTES_W-1:0] lim;
		lim = usable_capacity();
		return (fill_lvl >= lim) ? '0 : lim - fill_lvl;
	endfunction

	// Apply one command to the shadow state and return the beat it should produce.
	function automatic alloc_result_t apply_command(input cmd_t op,
			input logic [BYTES_W-1:0] size);
		alloc_result_t      r;
		logic [BYTES_W:0]   need;
		logic [BYTES_W+1:0] next_fill;
		logic [BYTES_W-1:0] top_hdr;
		r = '0;
		case (op)
			CMD_ALLOC: begin
				need = {1'b0, size} + {1'b0, HDR_SIZE};
				if (need <= {1'b0, room_left()} && rec_count < SLOT_CAP) begin
					next_fill = {2'b00, fill_lvl} + {1'b0, need};
					next_fill = next_fill + {{(BYTES_W+1){1'b0}}, next_fill[0]};
					// The even-rounding pad never runs past the capacity.
					if (next_fill > {2'b00, usable_capacity()}) begin
						next_fill = {2'b00, usable_capacity()};
					end
					hdr_offs[rec_count] = fill_lvl;
					r.ok = 1'b1;
					r.data_offset = fill_lvl + HDR_SIZE;
					rec_count = rec_count + 1'b1;
					fill_lvl = next_fill[BYTES_W-1:0];
				end
			end
			CMD_POP: begin
				if (rec_count != '0) begin
					top_hdr = hdr_offs[rec_count - 1'b1];
					rec_count = rec_count - 1'b1;
					fill_lvl = top_hdr;
					r.ok = 1'b1;
					r.data_offset = top_hdr + HDR_SIZE;
				end
			end
			CMD_PEEK: begin
				if (rec_count != '0) begin
					r.ok = 1'b1;
					r.data_offset = hdr_offs[rec_count - 1'b1] + HDR_SIZE;
				end
			end
			CMD_CLEAR: begin
				fill_lvl = '0;
				rec_count = '0;
				r.ok = 1'b1;
			end
			default: begin
				r.ok = 1'b0;
			end
		endcase
		r.used_bytes   = fill_lvl;
		r.free_bytes   = room_left();
		r.object_count = rec_count;
		r.is_empty     = (fill_lvl == '0);
		r.is_full      = (fill_lvl == usable_capacity());
		return r;
	endfunction

	// Builds a hand-written expected beat for the directed table.
	function automatic alloc_result_t literal_result(input int okv, input int off,
			input int used, input int room, input int cnt, input int emp, input int ful);
		alloc_result_t r;
		r.ok           = okv[0];
		r.data_offset  = off[BYTES_W-1:0];
		r.used_bytes   = used[BYTES_W-1:0];
		r.free_bytes   = room[BYTES_W-1:0];
		r.object_count = cnt[COUNT_W-1:0];
		r.is_empty     = emp[0];
		r.is_full      = ful[0];
		return r;
	endfunction

	// Stall length: mostly short, now and then long.
	function automatic int pause_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 2);
		end else if (r < 95) begin
			return $urandom_range(3, 8);
		end
		return $urandom_range(15, 40);
	endfunction

	// Gap before the next command beat; none at all in quiet stretches.
	function automatic int idle_length();
		if (quiet || $urandom_range(0, 99) < 55) begin
			return 0;
		end
		return pause_length();
	endfunction

	// Offer one command beat, then record what it should produce once accepted.
	task automatic issue(input cmd_t op, input logic [BYTES_W-1:0] size,
			input logic typed, input alloc_result_t lit);
		alloc_result_t pred;
		int gap;
		gap = idle_length();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		obj_size <= size;
		do @(posedge clk); while (in_stall !== 1'b0);
		pred = apply_command(op, size);
		expected_q.push_back(typed ? lit : pred);
	endtask

	// Stop offering beats and wait until every expected beat has come back.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
	endtask

	// Capacity writes happen only with the block drained.
	task automatic write_capacity(input logic [BYTES_W-1:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we  <= 1'b0;
		cap_reg = value;
	endtask

	// Receiver pacing: random stalls, or one long hold-off when asked.
	initial begin : rx_pacing
		int run;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				run = pause_length();
				out_stall <= 1'b1;
				repeat (run) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Compare every accepted result beat with the oldest expectation.
	always @(posedge clk) begin : result_check
		alloc_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_q.size() == 0) begin
				$error("result beat arrived with nothing expected");
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				if (ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, ok);
					fail_count++;
				end
				if (data_offset !== want.data_offset) begin
					$error("data_offset: expected %0d, got %0d", want.data_offset, data_offset);
					fail_count++;
				end
				if (used_bytes !== want.used_bytes) begin
					$error("used_bytes: expected %0d, got %0d", want.used_bytes, used_bytes);
					fail_count++;
				end
				if (free_bytes !== want.free_bytes) begin
					$error("free_bytes: expected %0d, got %0d", want.free_bytes, free_bytes);
					fail_count++;
				end
				if (object_count !== want.object_count) begin
					$error("object_count: expected %0d, got %0d", want.object_count,
						object_count);
					fail_count++;
				end
				if (is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
					fail_count++;
				end
				if (is_full !== want.is_full) begin
					$error("is_full: expected %0d, got %0d", want.is_full, is_full);
					fail_count++;
				end
			end
		end
	end

	// Give up when nothing moves on either side for too long.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_stall === 1'b0) ||
				(out_valid === 1'b1 && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[variable_record_stack_allocator] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		logic [BYTES_W-1:0] phase_caps [NUM_PHASES];
		logic [BYTES_W-1:0] sz;
		cmd_t op;
		int k;
		int i;
		int r;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		cmd       = CMD_ALLOC;
		obj_size  = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;

		// Directed rows: extremes, every command, and each corner of the fill logic.
		dir_rows = '{
			'{1'b0, CMD_PEEK,  13'd0,    1'b1, literal_result(0, 0, 0, 4096, 0, 1, 0)},
			'{1'b0, CMD_POP,   13'd8191, 1'b1, literal_result(0, 0, 0, 4096, 0, 1, 0)},
			'{1'b0, CMD_ALLOC, 13'd0,    1'b1, literal_result(1, 2, 2, 4094, 1, 0, 0)},
			'{1'b0, CMD_ALLOC, 13'd1,    1'b1, literal_result(1, 4, 6, 4090, 2, 0, 0)},
			'{1'b0, CMD_PEEK,  13'd8191, 1'b1, literal_result(1, 4, 6, 4090, 2, 0, 0)},
			'{1'b0, CMD_ALLOC, 13'd8191, 1'b1, literal_result(0, 0, 6, 4090, 2, 0, 0)},
			'{1'b0, CMD_POP,   13'd0,    1'b1, literal_result(1, 4, 2, 4094, 1, 0, 0)},
			'{1'b0, CMD_ALLOC, 13'd4092, 1'b1, literal_result(1, 4, 4096, 0, 2, 0, 1)},
			'{1'b0, CMD_ALLOC, 13'd0,    1'b1, literal_result(0, 0, 4096, 0, 2, 0, 1)},
			// Capacity shrinks below the fill level.
			'{1'b1, CMD_CLEAR, 13'd100,  1'b0, '0},
			'{1'b0, CMD_ALLOC, 13'd0,    1'b1, literal_result(0, 0, 4096, 0, 2, 0, 0)},
			'{1'b0, CMD_POP,   13'd0,    1'b1, literal_result(1, 4, 2, 98, 1, 0, 0)},
			'{1'b0, CMD_CLEAR, 13'd8191, 1'b1, literal_result(1, 0, 0, 100, 0, 1, 0)},
			// Zero capacity: empty and full at once.
			'{1'b1, CMD_CLEAR, 13'd0,    1'b0, '0},
			'{1'b0, CMD_ALLOC, 13'd0,    1'b1, literal_result(0, 0, 0, 0, 0, 1, 1)},
			'{1'b0, CMD_CLEAR, 13'd0,    1'b1, literal_result(1, 0, 0, 0, 0, 1, 1)},
			// Odd capacity: the pad is cut off at the capacity.
			'{1'b1, CMD_CLEAR, 13'd5,    1'b0, '0},
			'{1'b0, CMD_ALLOC, 13'd3,    1'b1, literal_result(1, 2, 5, 0, 1, 0, 1)},
			'{1'b0, CMD_POP,   13'd0,    1'b1, literal_result(1, 2, 0, 5, 0, 1, 0)},
			// Capacity above the buffer is clipped to the buffer size.
			'{1'b1, CMD_CLEAR, 13'd8191, 1'b0, '0},
			'{1'b0, CMD_ALLOC, 13'd4094, 1'b1, literal_result(1, 2, 4096, 0, 1, 0, 1)},
			'{1'b0, CMD_PEEK,  13'd0,    1'b1, literal_result(1, 2, 4096, 0, 1, 0, 1)},
			'{1'b0, CMD_CLEAR, 13'd0,    1'b1, literal_result(1, 0, 0, 4096, 0, 1, 0)},
			'{1'b0, CMD_ALLOC, 13'd5,    1'b0, '0},
			'{1'b0, CMD_ALLOC, 13'd2730, 1'b0, '0},
			'{1'b0, CMD_POP,   13'd8191, 1'b0, '0},
			'{1'b1, CMD_CLEAR, 13'd4096, 1'b0, '0}
		};
		phase_caps = '{13'd4096, 13'd1, 13'd4095, 13'd8191, 13'd777, 13'd2,
			13'($urandom_range(0, 8191))};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < NUM_DIR; k++) begin
			if (dir_rows[k].is_cfg) begin
				write_capacity(dir_rows[k].value);
			end else begin
				issue(dir_rows[k].op, dir_rows[k].value, dir_rows[k].typed, dir_rows[k].lit);
			end
		end

		// Random phases, each under its own capacity; state carries over between them.
		for (k = 0; k < NUM_PHASES; k++) begin
			write_capacity(phase_caps[k]);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (i == 10) begin
					quiet = 1'b1;
				end
				if (i == 30) begin
					quiet = 1'b0;
				end
				// Long receiver hold-off while commands keep coming back to back.
				if (k == 1 && i == 40) begin
					hold_req = 1'b1;
					quiet = 1'b1;
				end
				if (k == 1 && i == 64) begin
					quiet = 1'b0;
				end
				// Sender pauses until the block has drained.
				if (i == 50) begin
					settle();
				end
				r = $urandom_range(0, 99);
				if (r < 50) begin
					op = CMD_ALLOC;
				end else if (r < 76) begin
					op = CMD_POP;
				end else if (r < 97) begin
					op = CMD_PEEK;
				end else begin
					op = CMD_CLEAR;
				end
				r = $urandom_range(0, 99);
				if (r < 60) begin
					sz = 13'($urandom_range(0, 15));
				end else if (r < 85) begin
					sz = 13'($urandom_range(16, 300));
				end else if (r < 96) begin
					sz = 13'($urandom_range(301, 4100));
				end else begin
					sz = 13'($urandom_range(4101, 8191));
				end
				issue(op, sz, 1'b0, '0);
			end
		end

		// Stack up a long run of minimum-size records, then unwind part of it.
		write_capacity(BUF_LIMIT);
		issue(CMD_CLEAR, '0, 1'b0, '0);
		for (i = 0; i < FILL_ITEMS; i++) begin
			op = (i % 100 == 99) ? CMD_PEEK : CMD_ALLOC;
			issue(op, '0, 1'b0, '0);
		end
		for (i = 0; i < 40; i++) begin
			op = ($urandom_range(0, 2) == 0) ? CMD_PEEK : CMD_POP;
			issue(op, 13'($urandom_range(0, 8191)), 1'b0, '0);
		end
		issue(CMD_CLEAR, '0, 1'b0, '0);

		// Drain, then give any stray beat time to arrive.
		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("[variable_record_stack_allocator] OK");
		end else begin
			$display("[variable_record_stack_allocator] ERROR");
		end
		$finish;
	end

endmodule

// File: variable_record_stack_allocator.f
rtl/core/vrsa_pkg.sv
rtl/core/vrsa_hdr_store.sv
rtl/core/vrsa_ctrl.sv
rtl/core/variable_record_stack_allocator.sv
tb/sv/tb.sv
